@@ src/msmp_pkg.sv @@
// Shared types and constants for the MD5/SHA1 message padder.
// Used by the controller, the datapath and the top level. No dependencies.
package msmp_pkg;

   localparam logic ACTION_DATA   = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;

   localparam logic [7:0] MARKER_BYTE = 8'h80;
   // Zero words after the marker: 13 minus bits 5:2 of the byte count, mod 16
   localparam logic [3:0] ZERO_WORDS_BASE = 4'd13;

   localparam int  CSR_ADDR_WIDTH = 3;
   localparam logic CSR_IDX_HASH_MODE = 1'b0;

   localparam logic MODE_MD5  = 1'b0;
   localparam logic MODE_SHA1 = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] fifo_word;
      logic        last_word;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD_ZERO,
      ST_PAD_LEN_FIRST,
      ST_PAD_LEN_LAST
   } ctrl_state_type;

   typedef struct packed {
      logic take_byte;
      logic take_finish;
      logic emit_zero;
      logic emit_len_first;
      logic emit_len_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic no_zero_words;
      logic last_zero;
   } dp_status_type;

endpackage

@@ src/msmp_ctrl.sv @@
// Padder controller: sequences data packing and the padding tail.
// Depends on msmp_pkg for the state, command and status types.
module msmp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   input  msmp_pkg::dp_status_type status,
   output logic                    req_stall,
   output msmp_pkg::ctrl_cmd_type  cmd
);

   msmp_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msmp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msmp_pkg::ST_IDLE: begin
            if (req_valid && status.out_free && (req_action == msmp_pkg::ACTION_FINISH)) begin
               state_in = status.no_zero_words ? msmp_pkg::ST_PAD_LEN_FIRST
                                               : msmp_pkg::ST_PAD_ZERO;
            end
         end
         msmp_pkg::ST_PAD_ZERO: begin
            if (status.out_free && status.last_zero) begin
               state_in = msmp_pkg::ST_PAD_LEN_FIRST;
            end
         end
         msmp_pkg::ST_PAD_LEN_FIRST: begin
            if (status.out_free) begin
               state_in = msmp_pkg::ST_PAD_LEN_LAST;
            end
         end
         msmp_pkg::ST_PAD_LEN_LAST: begin
            if (status.out_free) begin
               state_in = msmp_pkg::ST_IDLE;
            end
         end
         default: state_in = msmp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         msmp_pkg::ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               if (req_action == msmp_pkg::ACTION_DATA) begin
                  cmd.take_byte = 1'b1;
               end else begin
                  cmd.take_finish = 1'b1;
               end
            end
         end
         msmp_pkg::ST_PAD_ZERO:      cmd.emit_zero      = status.out_free;
         msmp_pkg::ST_PAD_LEN_FIRST: cmd.emit_len_first = status.out_free;
         msmp_pkg::ST_PAD_LEN_LAST:  cmd.emit_len_last  = status.out_free;
         default: cmd = '0;
      endcase
   end

   // the zero-word state is only entered with words left to send
   a_zero_state_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msmp_pkg::ST_PAD_ZERO) |-> !$past(cmd.take_finish && status.no_zero_words))
      else $error("entered zero padding with no zero words due");

endmodule

@@ src/msmp_dp.sv @@
// Padder datapath: word packing, byte count, zero counter and output register.
// Depends on msmp_pkg for payload, command and status types and constants.
module msmp_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      hash_mode,
   input  logic [7:0]                data_byte,
   input  msmp_pkg::ctrl_cmd_type    cmd,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output msmp_pkg::rsp_payload_type rsp_payload,
   output msmp_pkg::dp_status_type   status
);

   logic [23:0] partial_word_ff, partial_word_in;
   logic [1:0]  partial_count_ff, partial_count_in;
   logic [60:0] message_bytes_ff, message_bytes_in;
   logic [3:0]  zero_cnt_ff, zero_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   msmp_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [4:0]  byte_shift;
   logic [31:0] packed_word;
   logic [31:0] marker_word;
   logic [63:0] bit_length;
   logic [3:0]  zero_words;
   logic        load_out;

   function automatic logic [31:0] swap_bytes(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   assign byte_shift  = {partial_count_ff, 3'b000};
   assign packed_word = {8'h00, partial_word_ff} | ({24'h000000, data_byte} << byte_shift);
   assign marker_word = {8'h00, partial_word_ff} |
                        ({24'h000000, msmp_pkg::MARKER_BYTE} << byte_shift);
   assign bit_length  = {message_bytes_ff, 3'b000};
   assign zero_words  = msmp_pkg::ZERO_WORDS_BASE - message_bytes_ff[5:2];

   assign status.out_free      = !rsp_valid_ff || !rsp_stall;
   assign status.no_zero_words = (zero_words == 4'd0);
   assign status.last_zero     = (zero_cnt_ff == 4'd1);

   assign load_out = (cmd.take_byte && (partial_count_ff == 2'd3)) || cmd.take_finish ||
                     cmd.emit_zero || cmd.emit_len_first || cmd.emit_len_last;

   always_comb begin
      partial_word_in  = partial_word_ff;
      partial_count_in = partial_count_ff;
      message_bytes_in = message_bytes_ff;
      zero_cnt_in      = zero_cnt_ff;
      rsp_payload_in   = rsp_payload_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (cmd.take_byte) begin
         message_bytes_in = message_bytes_ff + 61'd1;
         if (partial_count_ff == 2'd3) begin
            partial_word_in          = '0;
            partial_count_in         = 2'd0;
            rsp_payload_in.fifo_word = packed_word;
            rsp_payload_in.last_word = 1'b0;
         end else begin
            partial_word_in  = packed_word[23:0];
            partial_count_in = partial_count_ff + 2'd1;
         end
      end
      if (cmd.take_finish) begin
         zero_cnt_in              = zero_words;
         rsp_payload_in.fifo_word = marker_word;
         rsp_payload_in.last_word = 1'b0;
      end
      if (cmd.emit_zero) begin
         zero_cnt_in              = zero_cnt_ff - 4'd1;
         rsp_payload_in.fifo_word = '0;
         rsp_payload_in.last_word = 1'b0;
      end
      if (cmd.emit_len_first) begin
         rsp_payload_in.fifo_word = (hash_mode == msmp_pkg::MODE_SHA1) ?
                                    swap_bytes(bit_length[63:32]) : bit_length[31:0];
         rsp_payload_in.last_word = 1'b0;
      end
      if (cmd.emit_len_last) begin
         rsp_payload_in.fifo_word = (hash_mode == msmp_pkg::MODE_SHA1) ?
                                    swap_bytes(bit_length[31:0]) : bit_length[63:32];
         rsp_payload_in.last_word = 1'b1;
         // message closed: start the next one from scratch
         partial_word_in  = '0;
         partial_count_in = 2'd0;
         message_bytes_in = '0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_word_ff  <= '0;
         partial_count_ff <= 2'd0;
         message_bytes_ff <= '0;
         zero_cnt_ff      <= 4'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         partial_word_ff  <= partial_word_in;
         partial_count_ff <= partial_count_in;
         message_bytes_ff <= message_bytes_in;
         zero_cnt_ff      <= zero_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_count_tracks_bytes: assert property (@(posedge clock) disable iff (reset)
      partial_count_ff == message_bytes_ff[1:0])
      else $error("partial byte count out of step with message byte count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(load_out && rsp_valid_ff && rsp_stall))
      else $error("output register loaded while holding an untaken transaction");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_len_last |=> (message_bytes_ff == '0) && (partial_word_ff == '0))
      else $error("message state not cleared after final length word");

endmodule

@@ src/md5_sha1_message_padder_top.sv @@
// Top level of the MD5/SHA1 message padder: CSR port, controller, datapath.
// Depends on msmp_pkg, msmp_ctrl and msmp_dp.
//
//  channel  direction  handshake           payload
//  req_     in         req_valid/req_stall   req_payload (action, data_byte)
//  rsp_     out        rsp_valid/rsp_stall   rsp_payload (fifo_word, last_word)
//  csr_     in/out     APB-style, pready=1   hash_mode at byte address 0
//
// Data bytes are taken one per cycle while idle and the output is free; every fourth one
// loads a word into the output register. A finish item emits a marker word, 0..15 zero words
// and two length words, one per cycle unless stalled, paced by the single output register.
// A stalled output holds its word and stalls the input side until it is taken.
// Synchronous reset clears the message state and sets hash_mode to MD5.
module md5_sha1_message_padder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  msmp_pkg::req_payload_type             req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output msmp_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [msmp_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   logic                     hash_mode_ff, hash_mode_in;
   logic                     csr_write;
   logic                     csr_index;
   msmp_pkg::ctrl_cmd_type   cmd;
   msmp_pkg::dp_status_type  status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[msmp_pkg::CSR_ADDR_WIDTH-1];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      hash_mode_in = hash_mode_ff;
      if (csr_write && (csr_index == msmp_pkg::CSR_IDX_HASH_MODE)) begin
         hash_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_mode_ff <= msmp_pkg::MODE_MD5;
      end else begin
         hash_mode_ff <= hash_mode_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         msmp_pkg::CSR_IDX_HASH_MODE: csr_prdata = {31'd0, hash_mode_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   msmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_payload.action),
      .status     (status),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   msmp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .hash_mode   (hash_mode_ff),
      .data_byte   (req_payload.data_byte),
      .cmd         (cmd),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .status      (status)
   );

endmodule
